### rtl/tcp_connection_slow_timer_eval_defines.svh
// Assertion macros used by the checker file.
`ifndef TCP_CONNECTION_SLOW_TIMER_EVAL_DEFINES_SVH
`define TCP_CONNECTION_SLOW_TIMER_EVAL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCSE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcse assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcse assertion failed");

`endif

### rtl/tcse_pkg.sv
package tcse_pkg;

  // Connection states that carry their own rules
  localparam logic [3:0] ST_ACTIVE_OPEN = 4'd2;
  localparam logic [3:0] ST_HALF_OPEN   = 4'd3;
  localparam logic [3:0] ST_HALF_CLOSED = 4'd6;
  localparam logic [3:0] ST_TIME_WAIT   = 4'd10;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SYN_RETX_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETX_LIMIT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIN_WAIT2_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_OPEN_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_WAIT_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OOSEQ_FACTOR    = 3'd5;

  // Register reset values
  localparam logic [3:0]  RST_SYN_RETX_LIMIT  = 4'd6;
  localparam logic [3:0]  RST_RETX_LIMIT      = 4'd12;
  localparam logic [15:0] RST_FIN_WAIT2_LIMIT = 16'd40;
  localparam logic [15:0] RST_HALF_OPEN_LIMIT = 16'd60;
  localparam logic [15:0] RST_TIME_WAIT_LIMIT = 16'd240;
  localparam logic [3:0]  RST_OOSEQ_FACTOR    = 4'd6;

  // RTO backoff shift per retransmit count, index clamps at the last entry
  localparam int unsigned BACKOFF_DEPTH = 13;
  localparam logic [3:0] BACKOFF_MAX_IDX = 4'd12;
  localparam logic [2:0] BACKOFF_TAB [BACKOFF_DEPTH] = '{
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7
  };

  localparam logic [15:0] SAT16 = 16'hFFFF;

  typedef struct packed {
    logic [3:0]  conn_state;
    logic [3:0]  retx_count;
    logic [15:0] retx_timer;
    logic [15:0] cur_rto;
    logic [14:0] srtt_scaled;
    logic [14:0] rtt_dev;
    logic [15:0] cong_window;
    logic [15:0] peer_window;
    logic [15:0] seg_size;
    logic        has_unacked;
    logic        has_ooseq;
    logic [31:0] idle_ticks;
  } in_t;

  typedef struct packed {
    logic        remove_conn;
    logic        do_retransmit;
    logic        drop_ooseq;
    logic [15:0] next_retx_timer;
    logic [15:0] next_rto;
    logic [15:0] next_cwnd;
    logic [16:0] next_ssthresh;
  } out_t;

  typedef struct packed {
    logic [3:0]  syn_retx_limit;
    logic [3:0]  retx_limit;
    logic [15:0] fin_wait2_limit;
    logic [15:0] half_open_limit;
    logic [15:0] time_wait_limit;
    logic [3:0]  ooseq_factor;
  } cfg_t;

endpackage

### rtl/tcp_connection_slow_timer_eval.sv
// TCP slow-tick connection evaluator.
// Feed one connection record per cycle on item_i with start_i high; a word
// is taken at a rising edge where start_i is high and busy_o is low.
// Each accepted word yields exactly one result word on result_o, marked by
// done_o for a single cycle. The record is captured
// in the input register on acceptance, evaluated by the logic behind it and
// captured in the result register on the next edge, where done_o rises.
// Throughput is one record per cycle; the path that sets the clock is the
// RTO backoff shift followed by the ooseq threshold multiply and compare.
// The receiver has no way to stall: sample result_o whenever done_o is high.
// Configuration uses a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i);
// write only while no record is in flight. Writes to unused indexes drop.
// Reset (rst_ni low, asynchronous) loads the register defaults, empties
// both pipeline stages and holds busy_o high until the first edge after
// reset is released.
module tcp_connection_slow_timer_eval import tcse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  in_t                   item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output out_t                  result_o
);

  cfg_t cfg;
  in_t  in_q;
  logic in_vld_q;
  out_t eval_res;
  out_t res_q;
  logic done_q;
  logic busy_q;
  logic accept;

  assign accept = start_i && !busy_q;

  tcse_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Hold busy out of reset until the first edge, then accept every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b1;
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      busy_q   <= 1'b0;
      in_vld_q <= accept;
      done_q   <= in_vld_q;
    end
  end

  // Input register: capture the record word on acceptance
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= item_i;
    end
  end

  tcse_eval u_eval (
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (eval_res)
  );

  // Result register: advance the evaluated word behind the valid stage
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= eval_res;
    end
  end

  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### rtl/tcse_cfg_regs.sv
module tcse_cfg_regs import tcse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYN_RETX_LIMIT:  cfg_d.syn_retx_limit  = cfg_data_i[3:0];
        CFG_RETX_LIMIT:      cfg_d.retx_limit      = cfg_data_i[3:0];
        CFG_FIN_WAIT2_LIMIT: cfg_d.fin_wait2_limit = cfg_data_i;
        CFG_HALF_OPEN_LIMIT: cfg_d.half_open_limit = cfg_data_i;
        CFG_TIME_WAIT_LIMIT: cfg_d.time_wait_limit = cfg_data_i;
        CFG_OOSEQ_FACTOR:    cfg_d.ooseq_factor    = cfg_data_i[3:0];
        default:             cfg_d = cfg_q; // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.syn_retx_limit  <= RST_SYN_RETX_LIMIT;
      cfg_q.retx_limit      <= RST_RETX_LIMIT;
      cfg_q.fin_wait2_limit <= RST_FIN_WAIT2_LIMIT;
      cfg_q.half_open_limit <= RST_HALF_OPEN_LIMIT;
      cfg_q.time_wait_limit <= RST_TIME_WAIT_LIMIT;
      cfg_q.ooseq_factor    <= RST_OOSEQ_FACTOR;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/tcse_backoff.sv
module tcse_backoff import tcse_pkg::*; (
  input  logic [14:0] srtt_scaled_i,
  input  logic [14:0] rtt_dev_i,
  input  logic [3:0]  retx_count_i,
  output logic [15:0] rto_o
);

  logic [3:0]  idx;
  logic [2:0]  shamt;
  logic [15:0] base;
  logic [22:0] shifted;

  // Clamp the count to the table, then shift the estimate and saturate
  assign idx     = (retx_count_i > BACKOFF_MAX_IDX) ? BACKOFF_MAX_IDX : retx_count_i;
  assign shamt   = BACKOFF_TAB[idx];
  assign base    = {4'd0, srtt_scaled_i[14:3]} + {1'b0, rtt_dev_i};
  assign shifted = {7'd0, base} << shamt;
  assign rto_o   = (shifted[22:16] != 7'd0) ? SAT16 : shifted[15:0];

endmodule

### rtl/tcse_eval.sv
module tcse_eval import tcse_pkg::*; (
  input  in_t  item_i,
  input  cfg_t cfg_i,
  output out_t result_o
);

  logic        is_time_wait;
  logic        is_active_open;
  logic        limit_hit;
  logic [15:0] timer_inc;
  logic        fire;
  logic [15:0] backoff_rto;
  logic [15:0] rto_fin;
  logic [15:0] win_min;
  logic [15:0] win_half;
  logic [16:0] ssth;
  logic [19:0] ooseq_thr;
  logic        fw2_expired;
  logic        half_open_expired;
  logic        tw_expired;

  tcse_backoff u_backoff (
    .srtt_scaled_i (item_i.srtt_scaled),
    .rtt_dev_i     (item_i.rtt_dev),
    .retx_count_i  (item_i.retx_count),
    .rto_o         (backoff_rto)
  );

  assign is_time_wait   = (item_i.conn_state == ST_TIME_WAIT);
  assign is_active_open = (item_i.conn_state == ST_ACTIVE_OPEN);

  assign limit_hit = (is_active_open && (item_i.retx_count == cfg_i.syn_retx_limit)) ||
                     (item_i.retx_count == cfg_i.retx_limit);

  assign timer_inc = (item_i.retx_timer == SAT16) ? item_i.retx_timer
                                                  : item_i.retx_timer + 16'd1;
  assign fire = !is_time_wait && !limit_hit && item_i.has_unacked &&
                (timer_inc >= item_i.cur_rto);

  // An active open still waiting for its answer keeps its RTO on a timeout
  assign rto_fin = (fire && !is_active_open) ? backoff_rto : item_i.cur_rto;

  assign win_min  = (item_i.cong_window < item_i.peer_window) ? item_i.cong_window
                                                              : item_i.peer_window;
  assign win_half = {1'b0, win_min[15:1]};
  assign ssth     = (win_half < item_i.seg_size) ? {item_i.seg_size, 1'b0}
                                                 : {1'b0, win_half};

  assign ooseq_thr = {4'd0, rto_fin} * {16'd0, cfg_i.ooseq_factor};

  assign fw2_expired       = (item_i.conn_state == ST_HALF_CLOSED) &&
                             (item_i.idle_ticks > {16'd0, cfg_i.fin_wait2_limit});
  assign half_open_expired = (item_i.conn_state == ST_HALF_OPEN) &&
                             (item_i.idle_ticks > {16'd0, cfg_i.half_open_limit});
  assign tw_expired        = item_i.idle_ticks > {16'd0, cfg_i.time_wait_limit};

  always_comb begin
    result_o.remove_conn     = is_time_wait ? tw_expired
                                            : (limit_hit || fw2_expired || half_open_expired);
    result_o.do_retransmit   = fire;
    result_o.drop_ooseq      = !is_time_wait && item_i.has_ooseq &&
                               (item_i.idle_ticks >= {12'd0, ooseq_thr});
    result_o.next_retx_timer = (is_time_wait || limit_hit) ? item_i.retx_timer : timer_inc;
    result_o.next_rto        = rto_fin;
    result_o.next_cwnd       = fire ? item_i.seg_size : item_i.cong_window;
    result_o.next_ssthresh   = fire ? ssth : 17'd0;
  end

endmodule

### rtl/tcse_checker.sv
`include "tcp_connection_slow_timer_eval_defines.svh"

module tcse_checker import tcse_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input in_t  item_i,
  input logic done_o,
  input out_t result_o
);

  logic acc;
  assign acc = start_i && !busy_o;

  `TCSE_ASSERT_SAME(a_done_follows_accept, clk_i, rst_ni, $past(acc, 2) && $past(rst_ni, 2), done_o)
  `TCSE_ASSERT_SAME(a_done_has_source, clk_i, rst_ni, done_o, $past(acc, 2))
  `TCSE_ASSERT_SAME(a_cwnd_collapse, clk_i, rst_ni, done_o && result_o.do_retransmit, result_o.next_cwnd == $past(item_i.seg_size, 2))
  `TCSE_ASSERT_NEXT(a_busy_once, clk_i, rst_ni, busy_o, !busy_o)

endmodule

bind tcp_connection_slow_timer_eval tcse_checker u_tcse_checker (.*);
